// ===== hw/rtl/wsum_pkg.sv =====
package wsum_pkg;

  localparam int PIX_W     = 8;
  localparam int COL_SUM_W = 10;
  localparam int WIN_SUM_W = 12;
  localparam int POS_W     = 6;
  localparam int CFG_W     = 7;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam logic [CFG_W-1:0] FRAME_SIZE_RESET = 7'd64;
  localparam int               FRAME_SIZE_MIN   = 3;

  typedef enum logic {
    REG_FRAME_ROWS = 1'b0,
    REG_FRAME_COLS = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic                 valid;
    logic                 window;
    logic                 last;
    logic [WIN_SUM_W-1:0] sum;
    logic [POS_W-1:0]     row;
    logic [POS_W-1:0]     col;
  } wsum_cand_t;

  typedef struct packed {
    logic [WIN_SUM_W-1:0] max_sum;
    logic [POS_W-1:0]     max_row;
    logic [POS_W-1:0]     max_col;
    logic [WIN_SUM_W-1:0] min_sum;
    logic [POS_W-1:0]     min_row;
    logic [POS_W-1:0]     min_col;
  } wsum_result_t;

endpackage

// ===== hw/rtl/wsum_ram.sv =====
module wsum_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/wsum_track.sv =====
module wsum_track (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  restart_i,
  input  wsum_pkg::wsum_cand_t  cand_i,
  output logic                  res_valid_o,
  input  logic                  res_stall_i,
  output wsum_pkg::wsum_result_t res_o
);

  import wsum_pkg::*;

  wsum_result_t best_d, best_q;
  logic         seen_q;
  logic         res_valid_q;
  wsum_result_t res_q;

  always_comb begin
    best_d = best_q;
    if (cand_i.valid && cand_i.window) begin
      if (!seen_q || (cand_i.sum > best_q.max_sum)) begin
        best_d.max_sum = cand_i.sum;
        best_d.max_row = cand_i.row;
        best_d.max_col = cand_i.col;
      end
      if (!seen_q || (cand_i.sum < best_q.min_sum)) begin
        best_d.min_sum = cand_i.sum;
        best_d.min_row = cand_i.row;
        best_d.min_col = cand_i.col;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q      <= '0;
      seen_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (restart_i) begin
        best_q <= '0;
        seen_q <= 1'b0;
      end else if (cand_i.valid) begin
        if (cand_i.last) begin
          best_q <= '0;
          seen_q <= 1'b0;
        end else begin
          best_q <= best_d;
          seen_q <= seen_q | cand_i.window;
        end
      end
      if (cand_i.valid && cand_i.last) begin
        res_valid_q <= 1'b1;
      end else if (res_valid_q && !res_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cand_i.valid && cand_i.last) begin
      res_q <= best_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== hw/rtl/window_sum_extremum_search_unit.sv =====
// A frame's result follows its last pixel through stage 1, candidate and result registers.
// Throughput: one pixel per cycle unless stalled, set by one line store read and write each cycle.
// The pixel input stalls only when a frame's last pixel would meet a result still held.
// Reset is asynchronous and active low; it clears counters, extremes and handshakes,
// and sets both frame sizes to 64. Line store contents stay unset until written.
module window_sum_extremum_search_unit #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [wsum_pkg::APB_AW-1:0]    paddr,
  input  logic [wsum_pkg::APB_DW-1:0]    pwdata,
  output logic [wsum_pkg::APB_DW-1:0]    prdata,
  output logic                           pready,
  input  logic                           pixel_valid_i,
  output logic                           pixel_stall_o,
  input  logic [wsum_pkg::PIX_W-1:0]     pixel_i,
  output logic                           result_valid_o,
  input  logic                           result_stall_i,
  output logic [wsum_pkg::WIN_SUM_W-1:0] max_sum_o,
  output logic [wsum_pkg::POS_W-1:0]     max_row_o,
  output logic [wsum_pkg::POS_W-1:0]     max_col_o,
  output logic [wsum_pkg::WIN_SUM_W-1:0] min_sum_o,
  output logic [wsum_pkg::POS_W-1:0]     min_row_o,
  output logic [wsum_pkg::POS_W-1:0]     min_col_o
);

  import wsum_pkg::*;

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int ROW_RESET_LAST = ((64 > MAX_ROWS) ? MAX_ROWS : 64) - 1;
  localparam int COL_RESET_LAST = ((64 > MAX_COLS) ? MAX_COLS : 64) - 1;

  // Configuration registers and their clamped last indexes.
  logic [CFG_W-1:0] rows_q, cols_q;
  logic [RW-1:0]    row_last_q, row_last_d;
  logic [CW-1:0]    col_last_q, col_last_d;
  logic [CFG_W-1:0] wval;
  logic             cfg_wr;
  cfg_reg_e         cfg_idx;

  assign wval    = pwdata[CFG_W-1:0];
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = cfg_reg_e'(paddr[2]);
  assign pready  = 1'b1;

  always_comb begin
    if (int'(wval) < FRAME_SIZE_MIN) begin
      row_last_d = RW'(FRAME_SIZE_MIN - 1);
    end else if (int'(wval) > MAX_ROWS) begin
      row_last_d = RW'(MAX_ROWS - 1);
    end else begin
      row_last_d = RW'(wval - 7'd1);
    end
    if (int'(wval) < FRAME_SIZE_MIN) begin
      col_last_d = CW'(FRAME_SIZE_MIN - 1);
    end else if (int'(wval) > MAX_COLS) begin
      col_last_d = CW'(MAX_COLS - 1);
    end else begin
      col_last_d = CW'(wval - 7'd1);
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_FRAME_ROWS: prdata = {{(APB_DW-CFG_W){1'b0}}, rows_q};
      REG_FRAME_COLS: prdata = {{(APB_DW-CFG_W){1'b0}}, cols_q};
      default:        prdata = '0;
    endcase
  end

  // Frame position counters.
  logic [RW-1:0] row_q;
  logic [CW-1:0] col_q;
  logic          accept, col_wrap, next_last;

  assign col_wrap      = (col_q == col_last_q);
  assign next_last     = col_wrap && (row_q == row_last_q);
  assign pixel_stall_o = next_last && result_valid_o && result_stall_i;
  assign accept        = pixel_valid_i && !pixel_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q     <= FRAME_SIZE_RESET;
      cols_q     <= FRAME_SIZE_RESET;
      row_last_q <= RW'(ROW_RESET_LAST);
      col_last_q <= CW'(COL_RESET_LAST);
      row_q      <= '0;
      col_q      <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_FRAME_ROWS: begin
          rows_q     <= wval;
          row_last_q <= row_last_d;
        end
        REG_FRAME_COLS: begin
          cols_q     <= wval;
          col_last_q <= col_last_d;
        end
        default: begin
          rows_q <= rows_q;
        end
      endcase
      row_q <= '0;
      col_q <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        col_q <= '0;
        row_q <= (row_q == row_last_q) ? '0 : row_q + RW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // Stage 1: line store read data lines up with the registered pixel.
  logic                 s1_valid_q, s1_win_q, s1_last_q;
  logic [PIX_W-1:0]     s1_pix_q;
  logic [CW-1:0]        s1_col_q;
  logic [POS_W-1:0]     s1_prow_q, s1_pcol_q;
  logic [RW+POS_W-1:0]  row_off;
  logic [CW+POS_W-1:0]  col_off;
  logic [2*PIX_W-1:0]   ls_rdata;
  logic [PIX_W-1:0]     ls_up, ls_lo;

  assign row_off = {{POS_W{1'b0}}, row_q} - (RW+POS_W)'(2);
  assign col_off = {{POS_W{1'b0}}, col_q} - (CW+POS_W)'(2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= pixel_i;
      s1_col_q  <= col_q;
      s1_win_q  <= (row_q >= RW'(2)) && (col_q >= CW'(2));
      s1_last_q <= next_last;
      s1_prow_q <= row_off[POS_W-1:0];
      s1_pcol_q <= col_off[POS_W-1:0];
    end
  end

  wsum_ram #(
    .WIDTH(2*PIX_W),
    .DEPTH(MAX_COLS)
  ) u_line_store (
    .clk_i  (clk_i),
    .we_i   (s1_valid_q),
    .waddr_i(s1_col_q),
    .wdata_i({ls_lo, s1_pix_q}),
    .raddr_i(col_q),
    .rdata_o(ls_rdata)
  );

  assign ls_up = ls_rdata[2*PIX_W-1:PIX_W];
  assign ls_lo = ls_rdata[PIX_W-1:0];

  // Column sums and window sum.
  logic [COL_SUM_W-1:0] cs_old_q, cs_new_q, col_sum;
  logic [WIN_SUM_W-1:0] win_sum;
  wsum_cand_t           cand_q;

  assign col_sum = COL_SUM_W'(ls_up) + COL_SUM_W'(ls_lo) + COL_SUM_W'(s1_pix_q);
  assign win_sum = WIN_SUM_W'(cs_old_q) + WIN_SUM_W'(cs_new_q) + WIN_SUM_W'(col_sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_old_q <= '0;
      cs_new_q <= '0;
      cand_q   <= '0;
    end else begin
      cand_q.valid <= s1_valid_q && !cfg_wr;
      if (cfg_wr) begin
        cs_old_q <= '0;
        cs_new_q <= '0;
      end else if (s1_valid_q) begin
        cs_old_q <= cs_new_q;
        cs_new_q <= col_sum;
      end
      if (s1_valid_q) begin
        cand_q.window <= s1_win_q;
        cand_q.last   <= s1_last_q;
        cand_q.sum    <= win_sum;
        cand_q.row    <= s1_prow_q;
        cand_q.col    <= s1_pcol_q;
      end
    end
  end

  wsum_result_t res;

  wsum_track u_track (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .restart_i  (cfg_wr),
    .cand_i     (cand_q),
    .res_valid_o(result_valid_o),
    .res_stall_i(result_stall_i),
    .res_o      (res)
  );

  assign max_sum_o = res.max_sum;
  assign max_row_o = res.max_row;
  assign max_col_o = res.max_col;
  assign min_sum_o = res.min_sum;
  assign min_row_o = res.min_row;
  assign min_col_o = res.min_col;

endmodule
